### rtl/core/qte_pkg.sv
// Shared types and constants for the quintic trajectory evaluator.
// Item formats, the controller-to-datapath command bundle and fixed-point widths.
// No dependencies.
package qte_pkg;

	// Default polynomial degree and the largest degree the command bundle can carry
	localparam int POLY_DEGREE = 5;
	localparam int MAX_DEGREE  = 8;
	localparam int K_MAX_W     = $clog2(MAX_DEGREE + 1);

	// Fixed-point formats: Q16.16 values, Q2.16 time
	localparam int FRAC_BITS   = 16;
	localparam int COEFF_WIDTH = 32;
	localparam int TIME_BITS   = FRAC_BITS + 2;
	localparam int OUT_W       = 32;

	// Item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// Input item
	typedef struct packed {
		logic               kind;
		logic               axis_select;
		logic [2:0]         coeff_index;
		logic signed [31:0] coeff_value;
		logic [17:0]        eval_time;
	} qte_req_t;

	// Result item
	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
		logic signed [31:0] x_velocity;
		logic signed [31:0] y_velocity;
		logic               overflow;
	} qte_res_t;

	// Controller to datapath command bundle
	typedef struct packed {
		logic               eval_start; // capture time, clear overflow
		logic               load;       // write one coefficient
		logic               issue;      // issue one Horner multiply
		logic               lane;       // 0 = x, 1 = y
		logic [K_MAX_W-1:0] k;          // coefficient position of this step
		logic               vel;        // velocity pass (weighted coefficients)
		logic               last;       // final step of this lane's pass
	} qte_cmd_t;

endpackage

### rtl/core/quintic_trajectory_evaluator.sv
// Quintic trajectory evaluator: x/y position and velocity by Horner's rule.
// Evaluate item: strobe on done after the RUN and FLUSH states that follow acceptance;
// one shared multiplier serves all 4*POLY_DEGREE+2 steps, interleaving the x and y chains.
// A new item is taken in the strobe cycle; busy holds off new items through RUN and FLUSH.
// Load items leave busy low. The receiver cannot stall the strobe.
// Reset clears all coefficients to zero and returns the sequencer to idle.
module quintic_trajectory_evaluator #(
	parameter int POLY_DEGREE = qte_pkg::POLY_DEGREE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  qte_pkg::qte_req_t request,
	output logic              busy,
	output logic              done,
	output qte_pkg::qte_res_t result
);

	localparam int LATENCY = 4 * POLY_DEGREE + 4;

	qte_pkg::qte_cmd_t cmd;

	// Sequencer
	qte_ctrl #(
		.POLY_DEGREE(POLY_DEGREE)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.cmd     (cmd)
	);

	// Arithmetic and storage
	qte_datapath #(
		.POLY_DEGREE(POLY_DEGREE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

	// Checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding evaluation");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.kind == qte_pkg::KIND_EVAL) |-> ##LATENCY done)
		else $error("evaluate item did not complete in the expected number of cycles");

endmodule

### rtl/core/qte_ctrl.sv
// Sequencer for the quintic trajectory evaluator.
// Accepts items, steps the Horner slots of both passes and raises the result strobe.
// Depends on qte_pkg.
module qte_ctrl #(
	parameter int POLY_DEGREE = qte_pkg::POLY_DEGREE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  qte_pkg::qte_req_t request,
	output logic              busy,
	output logic              done,
	output qte_pkg::qte_cmd_t cmd
);

	localparam int NCOEF  = POLY_DEGREE + 1;
	localparam int SLOT_W = $clog2(2 * NCOEF);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] slot_q;
	logic              vel_q;
	logic              done_q;

	logic accept;
	logic accept_eval;
	logic last_k;
	logic slot_last;

	// Handshake: the strobe cycle also takes a new item
	assign busy        = (state_q == ST_RUN) || (state_q == ST_FLUSH);
	assign accept      = start && !busy;
	assign accept_eval = accept && (request.kind == qte_pkg::KIND_EVAL);
	assign done        = done_q;

	// Slot decode: even slots x, odd slots y, coefficient position in upper bits
	assign last_k    = (int'(slot_q >> 1) == (vel_q ? POLY_DEGREE - 1 : POLY_DEGREE));
	assign slot_last = last_k && slot_q[0];

	// Commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.eval_start = accept_eval;
		cmd.load       = accept && (request.kind == qte_pkg::KIND_LOAD)
		                 && (int'(request.coeff_index) <= POLY_DEGREE);
		cmd.issue      = (state_q == ST_RUN);
		cmd.lane       = slot_q[0];
		cmd.k          = qte_pkg::K_MAX_W'(slot_q >> 1);
		cmd.vel        = vel_q;
		cmd.last       = last_k;
	end

	// State and registered strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			vel_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FLUSH);
			case (state_q)
				ST_IDLE, ST_EMIT: begin
					if (accept_eval) begin
						state_q <= ST_RUN;
						slot_q  <= '0;
						vel_q   <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (slot_last) begin
						slot_q <= '0;
						if (vel_q) begin
							state_q <= ST_FLUSH;
						end else begin
							vel_q <= 1'b1;
						end
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				ST_FLUSH: begin
					state_q <= ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/qte_datapath.sv
// Datapath of the quintic trajectory evaluator.
// Coefficient store, shared multiplier, round/accumulate/saturate stage and result registers.
// Depends on qte_pkg.
module qte_datapath #(
	parameter int POLY_DEGREE = qte_pkg::POLY_DEGREE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qte_pkg::qte_cmd_t cmd,
	input  qte_pkg::qte_req_t request,
	output qte_pkg::qte_res_t result
);

	localparam int NCOEF  = POLY_DEGREE + 1;
	localparam int K_W    = $clog2(NCOEF);
	localparam int WGT_W  = $clog2(POLY_DEGREE + 1) + 1;
	localparam int CW     = qte_pkg::COEFF_WIDTH;
	localparam int OW     = qte_pkg::OUT_W;
	localparam int TB     = qte_pkg::TIME_BITS;
	localparam int FB     = qte_pkg::FRAC_BITS;
	localparam int PROD_W = OW + TB + 1;
	localparam int WC_W   = CW + WGT_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam logic signed [PROD_W-1:0] RND_K = PROD_W'(2 ** (FB - 1));

	// Storage
	logic signed [CW-1:0] coef_q [2][NCOEF];
	logic signed [OW-1:0] acc_q  [2];
	logic signed [OW-1:0] pos_q  [2];
	logic signed [OW-1:0] velr_q [2];
	logic [TB-1:0]        t_q;
	logic                 ovf_q;

	// Multiply stage registers
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [WC_W-1:0]   wc_s1;
	logic                     valid_s1;
	logic                     lane_s1;
	logic                     last_s1;
	logic                     vel_s1;

	logic [K_W-1:0]           k_idx;
	logic [WGT_W-1:0]         wgt;
	logic signed [CW-1:0]     coef;
	logic signed [OW-1:0]     op_a;
	logic signed [PROD_W-1:0] prod;
	logic signed [WC_W-1:0]   wc;
	logic signed [PROD_W-1:0] rnd;
	logic signed [SUM_W-1:0]  sum;
	logic                     sat_hit;
	logic signed [OW-1:0]     sat_val;

	// Coefficient store, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				for (int i = 0; i < NCOEF; i++) begin
					coef_q[a][i] <= '0;
				end
			end
		end else if (cmd.load) begin
			coef_q[request.axis_select][K_W'(request.coeff_index)] <= request.coeff_value[CW-1:0];
		end
	end

	// Issue: acc * t on the shared multiplier, weighted coefficient alongside
	always_comb begin
		k_idx = K_W'(cmd.k);
		coef  = coef_q[cmd.lane][k_idx];
		wgt   = cmd.vel ? WGT_W'(POLY_DEGREE - int'(k_idx)) : WGT_W'(1);
		op_a  = (cmd.k == '0) ? '0 : acc_q[cmd.lane];
		prod  = op_a * $signed({1'b0, t_q});
		wc    = coef * $signed({1'b0, wgt});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prod_s1 <= prod;
			wc_s1   <= wc;
			lane_s1 <= cmd.lane;
			last_s1 <= cmd.last;
			vel_s1  <= cmd.vel;
		end
	end

	// Round half up, add weighted coefficient, clamp to 32 bits
	always_comb begin
		rnd     = (prod_s1 + RND_K) >>> FB;
		sum     = SUM_W'(rnd) + SUM_W'(wc_s1);
		sat_hit = !((&sum[SUM_W-1:OW-1]) || !(|sum[SUM_W-1:OW-1]));
		if (!sat_hit) begin
			sat_val = sum[OW-1:0];
		end else if (sum[SUM_W-1]) begin
			sat_val = {1'b1, {(OW-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(OW-1){1'b1}}};
		end
	end

	// Accumulators and result capture
	always_ff @(posedge clk) begin
		if (cmd.eval_start) begin
			t_q <= request.eval_time[TB-1:0];
		end
		if (valid_s1) begin
			acc_q[lane_s1] <= sat_val;
			if (last_s1) begin
				if (vel_s1) begin
					velr_q[lane_s1] <= sat_val;
				end else begin
					pos_q[lane_s1] <= sat_val;
				end
			end
		end
	end

	// Sticky overflow per evaluate item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.eval_start) begin
			ovf_q <= 1'b0;
		end else if (valid_s1 && sat_hit) begin
			ovf_q <= 1'b1;
		end
	end

	assign result.x_position = pos_q[0];
	assign result.y_position = pos_q[1];
	assign result.x_velocity = velr_q[0];
	assign result.y_velocity = velr_q[1];
	assign result.overflow   = ovf_q;

endmodule

### verif/quintic_trajectory_evaluator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for quintic_trajectory_evaluator: coefficient loads and path
// evaluations, every result checked against a Horner predictor held in the bench.
// Depends on qte_pkg and the quintic_trajectory_evaluator RTL.
module quintic_trajectory_evaluator_test;

	localparam int     NCOEF        = qte_pkg::POLY_DEGREE + 1;
	localparam int     LATENCY      = 4 * qte_pkg::POLY_DEGREE + 4;
	localparam int     STALL_LIMIT  = 4000;
	localparam int     TARGET_ITEMS = 1300;
	localparam int     PRINT_CAP    = 60;
	localparam int     TIME_W       = qte_pkg::TIME_BITS;
	localparam longint Q_MAX        = 64'sd2147483647;
	localparam longint Q_MIN        = -64'sd2147483648;
	localparam longint ROUND_HALF   = 64'sd1 <<< (qte_pkg::FRAC_BITS - 1);
	localparam logic [TIME_W-1:0] T_MAX = '1;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	qte_pkg::qte_req_t request = '0;
	logic              busy;
	logic              done;
	qte_pkg::qte_res_t result;

	// Bench copy of the coefficient store, highest power first per axis
	longint            coeff_bank [2*NCOEF];
	qte_pkg::qte_res_t pending_results [$];
	int                mismatch_count = 0;
	int                items_sent     = 0;
	int                idle_cycles    = 0;
	bit                no_gaps        = 1'b0;

	quintic_trajectory_evaluator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always #6 clk = ~clk;

	// Horner pass over one axis: position, or velocity with weights 5,4,3,2,1
	function automatic longint horner_eval(int base, longint t, bit vel, inout bit sat_seen);
		longint acc;
		longint term;
		int     steps;
		int     k;
		acc   = 0;
		steps = vel ? qte_pkg::POLY_DEGREE : NCOEF;
		for (k = 0; k < steps; k++) begin
			term = vel ? longint'(qte_pkg::POLY_DEGREE - k) * coeff_bank[base + k]
			           : coeff_bank[base + k];
			acc  = ((acc * t + ROUND_HALF) >>> qte_pkg::FRAC_BITS) + term;
			if (acc > Q_MAX) begin
				acc      = Q_MAX;
				sat_seen = 1'b1;
			end else if (acc < Q_MIN) begin
				acc      = Q_MIN;
				sat_seen = 1'b1;
			end
		end
		return acc;
	endfunction

	function automatic qte_pkg::qte_req_t load_req(bit axis, int idx, logic [31:0] value);
		qte_pkg::qte_req_t r;
		r             = '0;
		r.kind        = qte_pkg::KIND_LOAD;
		r.axis_select = axis;
		r.coeff_index = idx[2:0];
		r.coeff_value = value;
		r.eval_time   = 18'($urandom);   // ignored on a load
		return r;
	endfunction

	function automatic qte_pkg::qte_req_t eval_req(logic [TIME_W-1:0] t);
		qte_pkg::qte_req_t r;
		r             = '0;
		r.kind        = qte_pkg::KIND_EVAL;
		r.axis_select = 1'($urandom);   // the three fields below are ignored
		r.coeff_index = 3'($urandom);
		r.coeff_value = 32'($urandom);
		r.eval_time   = t;
		return r;
	endfunction

	// Anything at all: either kind, any index, any value
	function automatic qte_pkg::qte_req_t noise_req();
		qte_pkg::qte_req_t r;
		r.kind        = 1'($urandom);
		r.axis_select = 1'($urandom);
		r.coeff_index = 3'($urandom);
		r.coeff_value = 32'($urandom);
		r.eval_time   = 18'($urandom);
		return r;
	endfunction

	// Coefficients of mixed magnitude, mostly small enough to stay in range
	function automatic logic [31:0] path_coeff();
		logic signed [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 15) == 0)
			return v[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return v >>> $urandom_range(4, 31);
	endfunction

	function automatic logic [TIME_W-1:0] path_time();
		case ($urandom_range(0, 3))
			0: return TIME_W'($urandom_range(0, (1 << qte_pkg::FRAC_BITS) - 1));
			1: return $urandom_range(0, 1) ? T_MAX : '0;
			default: return TIME_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Offer one item after a random gap; on acceptance update the store or predict
	task automatic issue_item(qte_pkg::qte_req_t req);
		int                gap;
		qte_pkg::qte_res_t predicted;
		bit                sat_seen;
		longint            t;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		if (req.kind == qte_pkg::KIND_LOAD) begin
			if (req.coeff_index <= qte_pkg::POLY_DEGREE) begin
				coeff_bank[(req.axis_select ? NCOEF : 0) + int'(req.coeff_index)] =
					longint'($signed(req.coeff_value));
				items_sent++;
			end
		end else begin
			t        = longint'(req.eval_time);
			sat_seen = 1'b0;
			predicted.x_position = 32'(horner_eval(0, t, 1'b0, sat_seen));
			predicted.y_position = 32'(horner_eval(NCOEF, t, 1'b0, sat_seen));
			predicted.x_velocity = 32'(horner_eval(0, t, 1'b1, sat_seen));
			predicted.y_velocity = 32'(horner_eval(NCOEF, t, 1'b1, sat_seen));
			predicted.overflow   = sat_seen;
			pending_results.push_back(predicted);
			items_sent++;
		end
	endtask

	// Cleared store: every result is zero
	task automatic test_cleared_store();
		issue_item(eval_req('0));
		issue_item(eval_req(T_MAX));
	endtask

	// Full-scale coefficients at the longest time and at time zero
	task automatic test_saturation_extremes();
		issue_item(load_req(1'b0, 0, 32'h7FFF_FFFF));
		issue_item(load_req(1'b1, 0, 32'h8000_0000));
		issue_item(load_req(1'b0, qte_pkg::POLY_DEGREE, 32'h7FFF_FFFF));
		issue_item(load_req(1'b1, qte_pkg::POLY_DEGREE, 32'h8000_0000));
		issue_item(eval_req(T_MAX));
		issue_item(eval_req('0));
	endtask

	// Loads past the constant term leave the store alone
	task automatic test_ignored_loads();
		issue_item(load_req(1'b0, 6, 32'hFFFF_FFFF));
		issue_item(load_req(1'b1, 7, 32'h5555_5555));
		issue_item(eval_req(18'h15555));
	endtask

	// Exact half-LSB products: round half up on both signs
	task automatic test_rounding();
		issue_item(load_req(1'b0, 0, 32'h0));
		issue_item(load_req(1'b1, 0, 32'h0));
		issue_item(load_req(1'b0, qte_pkg::POLY_DEGREE, 32'h0));
		issue_item(load_req(1'b1, qte_pkg::POLY_DEGREE, 32'h0));
		issue_item(load_req(1'b0, qte_pkg::POLY_DEGREE - 1, 32'hFFFF_FFFF));
		issue_item(load_req(1'b1, qte_pkg::POLY_DEGREE - 1, 32'h0000_0001));
		issue_item(eval_req(18'h08000));
		issue_item(eval_req(18'h18000));
	endtask

	// Mostly whole paths loaded then sampled, with partial rewrites and noise
	task automatic test_random_paths();
		int order [2*NCOEF];
		int mode;
		int n;
		int i;
		int j;
		int tmp;
		while (items_sent < TARGET_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			mode    = $urandom_range(0, 9);
			if (mode <= 5) begin
				for (i = 0; i < 2*NCOEF; i++)
					order[i] = i;
				for (i = 2*NCOEF - 1; i > 0; i--) begin
					j        = $urandom_range(0, i);
					tmp      = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (i = 0; i < 2*NCOEF; i++)
					issue_item(load_req(order[i] >= NCOEF, order[i] % NCOEF, path_coeff()));
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					issue_item(eval_req(path_time()));
			end else if (mode <= 7) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					issue_item(load_req(1'($urandom_range(0, 1)),
						int'($urandom_range(0, qte_pkg::POLY_DEGREE)), path_coeff()));
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					issue_item(eval_req(path_time()));
			end else begin
				n = $urandom_range(3, 10);
				for (i = 0; i < n; i++)
					issue_item(noise_req());
			end
		end
		no_gaps = 1'b0;
	endtask

	// Result checker: each strobe against the oldest prediction
	always @(posedge clk) begin : result_check
		qte_pkg::qte_res_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result strobe with no evaluate item outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("x_position", result.x_position, want.x_position);
				check_field("y_position", result.y_position, want.y_position);
				check_field("x_velocity", result.x_velocity, want.x_velocity);
				check_field("y_velocity", result.y_velocity, want.y_velocity);
				if (result.overflow !== want.overflow)
					report_mismatch($sformatf("overflow got %b expected %b",
						result.overflow, want.overflow));
			end
		end
	end

	// Watchdog: cycles with no item taken and no result strobed
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		foreach (coeff_bank[i])
			coeff_bank[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_store();
		test_saturation_extremes();
		test_ignored_loads();
		test_rounding();
		test_random_paths();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/core/qte_pkg.sv
rtl/core/qte_ctrl.sv
rtl/core/qte_datapath.sv
rtl/core/quintic_trajectory_evaluator.sv
verif/quintic_trajectory_evaluator_test.sv
